FILE: design/idba_pkg.sv
package idba_pkg;

   localparam int ID_W             = 8;
   localparam int MAP_DEPTH        = 256;
   localparam int ROW_BITS         = 32;
   localparam int ROW_COUNT        = MAP_DEPTH / ROW_BITS;
   localparam int ROW_IDX_W        = $clog2(ROW_COUNT);
   localparam int BIT_IDX_W        = $clog2(ROW_BITS);
   localparam int ID_COUNT_DEFAULT = 256;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic            command;
      logic [ID_W-1:0] free_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] granted_id;
      logic            granted;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan_next;
      logic write_alloc;
      logic write_free;
      logic respond;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic found;
      logic last_row;
   } stat_type;

endpackage

FILE: design/idba_ctrl.sv
module idba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               command,
   input  idba_pkg::stat_type stat,
   output idba_pkg::ctl_type  ctl,
   output logic               busy
);

   idba_pkg::state_type state_ff;
   idba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idba_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (command == idba_pkg::CMD_FREE) ? idba_pkg::ST_FREE
                                                          : idba_pkg::ST_SCAN;
            end
         end
         idba_pkg::ST_SCAN: begin
            if (stat.found || stat.last_row) begin
               state_in = idba_pkg::ST_IDLE;
            end
         end
         idba_pkg::ST_FREE: begin
            state_in = idba_pkg::ST_IDLE;
         end
         default: state_in = idba_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      unique case (state_ff)
         idba_pkg::ST_IDLE: begin
            busy        = 1'b0;
            ctl.capture = start;
         end
         idba_pkg::ST_SCAN: begin
            if (stat.found) begin
               ctl.write_alloc = 1'b1;
               ctl.respond     = 1'b1;
            end else if (stat.last_row) begin
               ctl.respond = 1'b1;
            end else begin
               ctl.scan_next = 1'b1;
            end
         end
         idba_pkg::ST_FREE: begin
            ctl.write_free = 1'b1;
            ctl.respond    = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: design/idba_dp.sv
module idba_dp #(
   parameter int ID_COUNT = idba_pkg::ID_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  idba_pkg::req_type  req_data,
   input  idba_pkg::ctl_type  ctl,
   output idba_pkg::stat_type stat,
   output logic               rsp_valid,
   output idba_pkg::rsp_type  rsp_data
);

   localparam int IdLimit  = (ID_COUNT < idba_pkg::MAP_DEPTH) ? ID_COUNT
                                                              : idba_pkg::MAP_DEPTH;
   localparam int RowsUsed = (IdLimit <= 0) ? 1
                             : (IdLimit + idba_pkg::ROW_BITS - 1) / idba_pkg::ROW_BITS;
   localparam int IdxW     = idba_pkg::ID_W + 1;
   localparam logic [IdxW-1:0] LimitVal = IdxW'(IdLimit);
   localparam logic [idba_pkg::ROW_IDX_W-1:0] LastRow = idba_pkg::ROW_IDX_W'(RowsUsed - 1);

   logic [idba_pkg::ROW_BITS-1:0] map_mem [idba_pkg::ROW_COUNT];
   logic [idba_pkg::ROW_COUNT-1:0] row_valid_ff;

   logic [idba_pkg::ROW_BITS-1:0]  rdata_ff;
   logic                           rvalid_ff;
   logic [idba_pkg::ROW_IDX_W-1:0] row_ff;
   logic [idba_pkg::ROW_IDX_W-1:0] row_in;
   logic [idba_pkg::ID_W-1:0]      id_ff;
   logic                           rd_en;

   logic [idba_pkg::ROW_BITS-1:0]  row_data;
   logic [idba_pkg::ROW_BITS-1:0]  occupied;
   logic                           found;
   logic [idba_pkg::BIT_IDX_W-1:0] first_bit;
   logic                           id_ok;
   logic                           mem_we;
   logic [idba_pkg::ROW_BITS-1:0]  wdata;

   logic                           rsp_valid_ff;
   idba_pkg::rsp_type              rsp_data_ff;

   // read address: own row on free, row 0 on allocate, then walk upward
   always_comb begin
      rd_en  = ctl.capture || ctl.scan_next;
      row_in = row_ff;
      if (ctl.capture) begin
         row_in = (req_data.command == idba_pkg::CMD_FREE)
                  ? req_data.free_id[idba_pkg::ID_W-1 -: idba_pkg::ROW_IDX_W]
                  : '0;
      end else if (ctl.scan_next) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= map_mem[row_in];
         row_ff   <= row_in;
      end
      if (ctl.capture) begin
         id_ff <= req_data.free_id;
      end
      if (mem_we) begin
         map_mem[row_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (rd_en) begin
            rvalid_ff <= row_valid_ff[row_in];
         end
         if (mem_we) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   // never-written rows read as all free
   assign row_data = rvalid_ff ? rdata_ff : '0;

   // id 0 and ids past the limit count as taken
   always_comb begin
      for (int b = 0; b < idba_pkg::ROW_BITS; b++) begin
         occupied[b] = row_data[b]
                       || ({1'b0, row_ff, idba_pkg::BIT_IDX_W'(b)} == '0)
                       || ({1'b0, row_ff, idba_pkg::BIT_IDX_W'(b)} >= LimitVal);
      end
   end

   // lowest clear bit
   always_comb begin
      found     = 1'b0;
      first_bit = '0;
      for (int i = idba_pkg::ROW_BITS - 1; i >= 0; i--) begin
         if (!occupied[i]) begin
            found     = 1'b1;
            first_bit = idba_pkg::BIT_IDX_W'(i);
         end
      end
   end

   assign id_ok = (id_ff != '0) && ({1'b0, id_ff} < LimitVal);

   always_comb begin
      mem_we = 1'b0;
      wdata  = row_data;
      if (ctl.write_alloc) begin
         mem_we           = 1'b1;
         wdata[first_bit] = 1'b1;
      end else if (ctl.write_free && id_ok) begin
         mem_we = 1'b1;
         wdata[id_ff[idba_pkg::BIT_IDX_W-1:0]] = 1'b0;
      end
   end

   assign stat.found    = found;
   assign stat.last_row = (row_ff == LastRow);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         if (ctl.write_alloc) begin
            rsp_data_ff.granted_id <= {row_ff, first_bit};
            rsp_data_ff.granted    <= 1'b1;
         end else begin
            rsp_data_ff.granted_id <= '0;
            rsp_data_ff.granted    <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/id_bitmap_allocator_unit.sv
// allocate: scans the used map 32 ids per cycle from row 0 through the single map read
// port, stopping at the first row with a free id or at the last used row
// free: one read-modify-write of the id's row, with a registered result
// one item at a time; a new start is taken in the cycle the previous result shows
// synchronous active-high reset clears the controller and marks every map row unwritten,
// so all ids from 1 up to the limit read free; the receiver cannot stall rsp_valid
module id_bitmap_allocator_unit #(
   parameter int ID_COUNT = idba_pkg::ID_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  idba_pkg::req_type req_data,
   output logic              rsp_valid,
   output idba_pkg::rsp_type rsp_data
);

   idba_pkg::ctl_type  ctl;
   idba_pkg::stat_type stat;

   idba_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   idba_dp #(
      .ID_COUNT (ID_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
